>>> rtl/cna_pkg.sv
// Package for the channel normalisation and activation block.
// Holds command, register and activation codes, shared types and the
// constant functions that build the interpolation knot tables.
package cna_pkg;

  localparam int DEF_MAX_CHANNELS   = 256;
  localparam int DEF_TABLE_SEGMENTS = 256;

  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int KNOT_W     = 29;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_PROCESS = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPATIAL_SIZE    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LAYOUT_MODE     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVATION_MODE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SKIP_ENABLE     = 3'd4;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_RELU    = 3'd1;
  localparam logic [2:0] ACT_RELU_SQ = 3'd2;
  localparam logic [2:0] ACT_TANH    = 3'd3;
  localparam logic [2:0] ACT_SIGMOID = 3'd4;
  localparam logic [2:0] ACT_SELU    = 3'd5;
  localparam logic [2:0] ACT_SWISH   = 3'd6;
  localparam logic [2:0] ACT_MISH    = 3'd7;

  localparam int TAB_TANH = 0;
  localparam int TAB_SIG  = 1;
  localparam int TAB_EXP  = 2;
  localparam int TAB_MISH = 3;

  localparam logic signed [17:0] SELU_LAMBDA_Q16 = 18'sd68859;
  localparam logic signed [17:0] SELU_ALPHA_Q16  = 18'sd109659;

  localparam longint LN2_Q28  = 64'sd186065280;
  localparam longint LN2_HALF = LN2_Q28 / 2;
  localparam longint ONE30    = 64'sd1 <<< 30;
  localparam longint ONE32    = 64'sd1 <<< 32;

  typedef struct packed {
    logic [8:0]  channel_count;
    logic [12:0] spatial_size;
    logic        layout_mode;
  } pos_cfg_t;

  typedef struct packed {
    logic process;
    logic restart;
  } pos_ctl_t;

  function automatic logic [16:0] sat16(logic signed [35:0] v);
    if (v > 36'sd32767) begin
      return {1'b1, 16'h7fff};
    end else if (v < -36'sd32768) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, v[15:0]};
  endfunction

  // Truncating signed division by shift and subtract, elaboration only.
  function automatic longint sdiv(longint a, longint b);
    logic [63:0] na, nb, q, rem;
    logic        neg;
    int          k;
    neg = (a < 0) != (b < 0);
    na  = (a < 0) ? 64'(-a) : 64'(a);
    nb  = (b < 0) ? 64'(-b) : 64'(b);
    q   = '0;
    rem = '0;
    for (k = 63; k >= 0; k--) begin
      rem = {rem[62:0], na[k]};
      if (rem >= nb) begin
        rem  = rem - nb;
        q[k] = 1'b1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // e to the power y, y with 28 fraction bits, result with 32 fraction bits.
  function automatic longint exp_q32(longint y);
    longint a, n, r, term, sum;
    int     k;
    a = y + LN2_HALF;
    if (a >= 0) begin
      n = sdiv(a, LN2_Q28);
    end else begin
      n = -sdiv(-a + LN2_Q28 - 1, LN2_Q28);
    end
    r    = (y - n * LN2_Q28) * 16;
    term = ONE32;
    sum  = term;
    for (k = 1; k <= 14; k++) begin
      term = sdiv(sdiv(term * r, ONE32), longint'(k));
      sum  = sum + term;
    end
    if (n >= 0) begin
      return sum <<< n;
    end
    return (sum + (64'sd1 <<< (-n - 1))) >>> (-n);
  endfunction

  function automatic longint ratio16(longint num, longint den);
    return sdiv(num * 65536 + (den >>> 1), den);
  endfunction

  function automatic int knot(int kind, int k, int seg);
    longint t, at, e1, e2, th, f2, nn;
    t  = -(64'sd1 <<< 31) + sdiv(longint'(k) <<< 32, longint'(seg));
    at = (t < 0) ? -t : t;
    if (kind == TAB_EXP) begin
      return int'((exp_q32(t) + 32768) >>> 16);
    end else if (kind == TAB_TANH) begin
      e2 = exp_q32(-2 * at) >>> 2;
      th = ratio16(ONE30 - e2, ONE30 + e2);
      return int'((t < 0) ? -th : th);
    end
    e1 = exp_q32(-at) >>> 2;
    if (kind == TAB_SIG) begin
      if (t >= 0) begin
        return int'(ratio16(ONE30, ONE30 + e1));
      end
      return int'(ratio16(e1, ONE30 + e1));
    end
    if (t >= 0) begin
      f2 = (e1 * e1) >>> 30;
      return int'(ratio16(ONE30 + 2 * e1, ONE30 + 2 * e1 + 2 * f2));
    end
    nn = ((e1 * e1) >>> 30) + 2 * e1;
    return int'(ratio16(nn, nn + 2 * ONE30));
  endfunction

endpackage

>>> rtl/cna_if.sv
// Item channel interfaces of the channel normalisation block.
// Depends on nothing; carries valid, ready and the item payload.
interface cna_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         load_channel;
  logic signed [15:0] load_mean;
  logic signed [15:0] load_scale;
  logic signed [15:0] element_value;
  logic signed [15:0] skip_value;

  modport source (output valid, cmd, load_channel, load_mean, load_scale,
                  element_value, skip_value, input ready);
  modport sink (input valid, cmd, load_channel, load_mean, load_scale,
                element_value, skip_value, output ready);
endinterface

interface cna_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result_value;
  logic               saturated;

  modport source (output valid, result_value, saturated, input ready);
  modport sink (input valid, result_value, saturated, output ready);
endinterface

>>> rtl/cna_chan_mem.sv
// Per-channel mean and scale memory, one write and one read port.
// Read data is registered; the read holds while the pipeline stalls.
module cna_chan_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cna_position.sv
// Plane position and channel counters of the normalisation block.
// Uses cna_pkg for the counter control and configuration structs.
module cna_position import cna_pkg::*; #(
  parameter int CH_CAP = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  pos_ctl_t   ctl,
  input  pos_cfg_t   cfg,
  output logic [7:0] current_channel
);

  logic [11:0] plane_position;
  logic [8:0]  cc_eff;
  logic [12:0] ss_eff;
  logic [8:0]  ch_inc;
  logic [7:0]  ch_wrap;
  logic [12:0] pos_inc;

  always_comb begin
    if (cfg.channel_count == 9'd0) begin
      cc_eff = 9'd1;
    end else if (cfg.channel_count > 9'(CH_CAP)) begin
      cc_eff = 9'(CH_CAP);
    end else begin
      cc_eff = cfg.channel_count;
    end
    if (cfg.spatial_size == 13'd0) begin
      ss_eff = 13'd1;
    end else if (cfg.spatial_size > 13'd4096) begin
      ss_eff = 13'd4096;
    end else begin
      ss_eff = cfg.spatial_size;
    end
    ch_inc  = {1'b0, current_channel} + 9'd1;
    ch_wrap = (ch_inc >= cc_eff) ? 8'd0 : ch_inc[7:0];
    pos_inc = {1'b0, plane_position} + 13'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_position  <= '0;
      current_channel <= '0;
    end else priority if (ctl.restart) begin
      plane_position  <= '0;
      current_channel <= '0;
    end else if (ctl.process) begin
      if (cfg.layout_mode) begin
        current_channel <= ch_wrap;
      end else if (pos_inc >= ss_eff) begin
        plane_position  <= '0;
        current_channel <= ch_wrap;
      end else begin
        plane_position <= pos_inc[11:0];
      end
    end
  end

endmodule

>>> rtl/cna_act.sv
// Activation pipeline: table index, knot read, interpolation, products,
// rounding and final selection into the output register. Uses cna_pkg.
module cna_act import cna_pkg::*; #(
  parameter int TABLE_SEGMENTS = DEF_TABLE_SEGMENTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] x_in,
  input  logic               flag_in,
  input  logic [2:0]         mode,
  output logic               out_valid,
  output logic [15:0]        result,
  output logic               saturated
);

  localparam int KNOTS = TABLE_SEGMENTS + 1;
  localparam int IW    = $clog2(KNOTS);
  localparam int PW    = 13 + $clog2(TABLE_SEGMENTS + 1);

  logic signed [KNOT_W-1:0] tab_tanh [KNOTS];
  logic signed [KNOT_W-1:0] tab_sig  [KNOTS];
  logic signed [KNOT_W-1:0] tab_exp  [KNOTS];
  logic signed [KNOT_W-1:0] tab_mish [KNOTS];

  for (genvar k = 0; k < KNOTS; k++) begin : g_knot
    localparam int TANH_V = knot(TAB_TANH, k, TABLE_SEGMENTS);
    localparam int SIG_V  = knot(TAB_SIG, k, TABLE_SEGMENTS);
    localparam int EXP_V  = knot(TAB_EXP, k, TABLE_SEGMENTS);
    localparam int MISH_V = knot(TAB_MISH, k, TABLE_SEGMENTS);
    assign tab_tanh[k] = KNOT_W'(TANH_V);
    assign tab_sig[k]  = KNOT_W'(SIG_V);
    assign tab_exp[k]  = KNOT_W'(EXP_V);
    assign tab_mish[k] = KNOT_W'(MISH_V);
  end

  logic va, vb, vc, vd, ve, vf, vg;
  logic fa, fb, fc, fd, fe, ff, fg;
  logic signed [15:0] xa, xb, xc, xd, xe, xf, xg;

  // Index stage.
  logic signed [16:0] u_raw;
  logic [12:0]        u;
  logic [PW-1:0]      p;
  logic [IW-1:0]      i_a;
  logic [11:0]        f_a;

  always_comb begin
    u_raw = 17'(x_in) + 17'sd2048;
    if (u_raw < 0) begin
      u = 13'd0;
    end else if (u_raw > 17'sd4096) begin
      u = 13'd4096;
    end else begin
      u = u_raw[12:0];
    end
    p = PW'(u) * PW'(TABLE_SEGMENTS);
  end

  // Knot read stage.
  logic [IW-1:0]            hi_idx;
  logic signed [KNOT_W-1:0] tlo_n, thi_n, tlo_b, thi_b;
  logic [11:0]              f_b;

  always_comb begin
    hi_idx = (i_a == IW'(TABLE_SEGMENTS)) ? i_a : i_a + IW'(1);
    case (mode)
      ACT_TANH: begin
        tlo_n = tab_tanh[i_a];
        thi_n = tab_tanh[hi_idx];
      end
      ACT_SELU: begin
        tlo_n = tab_exp[i_a];
        thi_n = tab_exp[hi_idx];
      end
      ACT_MISH: begin
        tlo_n = tab_mish[i_a];
        thi_n = tab_mish[hi_idx];
      end
      default: begin
        tlo_n = tab_sig[i_a];
        thi_n = tab_sig[hi_idx];
      end
    endcase
  end

  // Interpolation stages.
  logic signed [KNOT_W:0]   kdiff;
  logic signed [12:0]       f_s;
  logic signed [42:0]       dp_n, dp_c;
  logic signed [KNOT_W-1:0] tlo_c;
  logic signed [31:0]       l_d;

  assign kdiff = (KNOT_W + 1)'(thi_b) - (KNOT_W + 1)'(tlo_b);
  assign f_s   = {1'b0, f_b};
  assign dp_n  = 43'(kdiff) * 43'(f_s);

  // Product stage.
  logic signed [15:0] rx_d;
  logic signed [17:0] op_a, op_b;
  logic signed [35:0] prod_e;
  logic signed [15:0] t34_e, t34_f, t34_g;
  logic               sh_e, neg_e, neg_f, neg_g;
  logic signed [27:0] r_f, r_g;
  logic signed [35:0] prod_g;

  always_comb begin
    rx_d = xd[15] ? 16'sd0 : xd;
    unique case (mode)
      ACT_RELU_SQ: begin
        op_a = 18'(rx_d);
        op_b = 18'(rx_d);
      end
      ACT_SELU: begin
        if (xd[15]) begin
          op_a = 18'(l_d - 32'sd65536);
          op_b = SELU_ALPHA_Q16;
        end else begin
          op_a = 18'(xd);
          op_b = SELU_LAMBDA_Q16;
        end
      end
      default: begin
        op_a = 18'(xd);
        op_b = 18'(l_d);
      end
    endcase
  end

  // Final selection.
  logic signed [15:0] rx_g;
  logic [16:0]        sat_r, sat_n;
  logic [15:0]        res_n;
  logic               sflag_n;

  always_comb begin
    rx_g  = xg[15] ? 16'sd0 : xg;
    sat_r = sat16(36'(r_g));
    sat_n = sat16((prod_g + 36'sd8388608) >>> 24);
    unique case (mode)
      ACT_NONE: begin
        res_n   = xg;
        sflag_n = 1'b0;
      end
      ACT_RELU: begin
        res_n   = rx_g;
        sflag_n = 1'b0;
      end
      ACT_TANH, ACT_SIGMOID: begin
        res_n   = t34_g;
        sflag_n = 1'b0;
      end
      ACT_SELU: begin
        res_n   = neg_g ? sat_n[15:0] : sat_r[15:0];
        sflag_n = neg_g ? sat_n[16] : sat_r[16];
      end
      default: begin
        res_n   = sat_r[15:0];
        sflag_n = sat_r[16];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve, vf, vg, out_valid} <= '0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      ve        <= vd;
      vf        <= ve;
      vg        <= vf;
      out_valid <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa  <= x_in;
      fa  <= flag_in;
      i_a <= IW'(p >> 12);
      f_a <= p[11:0];

      xb    <= xa;
      fb    <= fa;
      tlo_b <= tlo_n;
      thi_b <= thi_n;
      f_b   <= f_a;

      xc    <= xb;
      fc    <= fb;
      tlo_c <= tlo_b;
      dp_c  <= dp_n;

      xd  <= xc;
      fd  <= fc;
      l_d <= 32'(tlo_c) + 32'((dp_c + 43'sd2048) >>> 12);

      xe     <= xd;
      fe     <= fd;
      prod_e <= 36'(op_a) * 36'(op_b);
      t34_e  <= 16'((l_d + 32'sd128) >>> 8);
      sh_e   <= (mode != ACT_RELU_SQ);
      neg_e  <= xd[15];

      xf    <= xe;
      ff    <= fe;
      t34_f <= t34_e;
      neg_f <= neg_e;
      r_f   <= sh_e ? 28'((prod_e + 36'sd32768) >>> 16) : 28'((prod_e + 36'sd128) >>> 8);

      xg     <= xf;
      fg     <= ff;
      t34_g  <= t34_f;
      neg_g  <= neg_f;
      r_g    <= r_f;
      prod_g <= 36'($signed(r_f[17:0])) * 36'(SELU_LAMBDA_Q16);

      result    <= res_n;
      saturated <= fg | sflag_n;
    end
  end

endmodule

>>> rtl/channel_norm_activation_core.sv
// Top level of the channel normalisation and activation block.
// Uses cna_pkg, the channel interfaces, cna_chan_mem, cna_position, cna_act.
//
// Items enter on item_in. A load item writes the mean and scale of one
// channel, a restart item clears the plane position and channel counters,
// and a process item yields exactly one result on item_out. Load and
// restart items yield no result. Registers must be written on the write port
// only while the block is idle; the user must see to this, the block does not
// enforce it. The block takes one item per cycle unless a result waits on
// item_out untaken. A process item passes the registers v1 to v4 and those of
// cna_act; the memory read and the multipliers set the pipeline depth.
// Every stage advances together: when a result waits on item_out and the
// receiver does not take it, item_in.ready falls and the pipeline holds.
// Reset clears counters and all stage valid bits and presets the registers.
// The channel memory is not cleared: a channel must be loaded before use.
module channel_norm_activation_core import cna_pkg::*; #(
  parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
  parameter int TABLE_SEGMENTS = DEF_TABLE_SEGMENTS
) (
  input  logic                  clk,
  input  logic                  rst,
  cna_in_if.sink                item_in,
  cna_out_if.source             item_out,
  input  logic                  write_enable,
  input  logic [REG_IDX_W-1:0]  reg_index,
  input  logic [CFG_DATA_W-1:0] write_data
);

  localparam int MEM_DEPTH = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [8:0]  channel_count;
  logic [12:0] spatial_size;
  logic        layout_mode;
  logic [2:0]  activation_mode;
  logic        skip_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count   <= 9'd1;
      spatial_size    <= 13'd64;
      layout_mode     <= 1'b0;
      activation_mode <= ACT_NONE;
      skip_enable     <= 1'b0;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_CHANNEL_COUNT:   channel_count   <= write_data[8:0];
        REG_SPATIAL_SIZE:    spatial_size    <= write_data;
        REG_LAYOUT_MODE:     layout_mode     <= write_data[0];
        REG_ACTIVATION_MODE: activation_mode <= write_data[2:0];
        REG_SKIP_ENABLE:     skip_enable     <= write_data[0];
        default: begin
        end
      endcase
    end
  end

  logic       en, accept, load_we;
  pos_ctl_t   pos_ctl;
  pos_cfg_t   pos_cfg;
  logic [7:0] current_channel;

  assign en            = !item_out.valid || item_out.ready;
  assign item_in.ready = en;
  assign accept        = item_in.valid && en;
  assign load_we       = accept && (item_in.cmd == CMD_LOAD)
                         && ({1'b0, item_in.load_channel} < 9'(MEM_DEPTH));

  assign pos_ctl.process       = accept && (item_in.cmd == CMD_PROCESS);
  assign pos_ctl.restart       = accept && (item_in.cmd == CMD_RESTART);
  assign pos_cfg.channel_count = channel_count;
  assign pos_cfg.spatial_size  = spatial_size;
  assign pos_cfg.layout_mode   = layout_mode;

  cna_position #(.CH_CAP(MEM_DEPTH)) u_position (
    .clk             (clk),
    .rst             (rst),
    .ctl             (pos_ctl),
    .cfg             (pos_cfg),
    .current_channel (current_channel)
  );

  logic [31:0] mem_rdata;

  cna_chan_mem #(.DEPTH(MEM_DEPTH), .AW(MEM_AW)) u_chan_mem (
    .clk   (clk),
    .we    (load_we),
    .waddr (item_in.load_channel[MEM_AW-1:0]),
    .wdata ({item_in.load_mean, item_in.load_scale}),
    .re    (en),
    .raddr (current_channel[MEM_AW-1:0]),
    .rdata (mem_rdata)
  );

  logic               v1, v2, v3, v4;
  logic signed [15:0] elem1, skip1, skip2, skip3;
  logic signed [15:0] mean1, scale1, d2, scale2, x4;
  logic signed [16:0] diff;
  logic [16:0]        s_diff, s_scaled, s_skip;
  logic signed [31:0] prod3, scaled;
  logic signed [16:0] skip_sum;
  logic               f2, f3, f4;

  assign mean1    = mem_rdata[31:16];
  assign scale1   = mem_rdata[15:0];
  assign diff     = 17'(elem1) - 17'(mean1);
  assign s_diff   = sat16(36'(diff));
  assign scaled   = (prod3 + 32'sd128) >>> 8;
  assign s_scaled = sat16(36'(scaled));
  assign skip_sum = 17'($signed(s_scaled[15:0])) + 17'(skip3);
  assign s_skip   = sat16(36'(skip_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4} <= '0;
    end else if (en) begin
      v1 <= item_in.valid && (item_in.cmd == CMD_PROCESS);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      elem1  <= item_in.element_value;
      skip1  <= item_in.skip_value;
      d2     <= s_diff[15:0];
      f2     <= s_diff[16];
      scale2 <= scale1;
      skip2  <= skip1;
      prod3  <= 32'(d2) * 32'(scale2);
      f3     <= f2;
      skip3  <= skip2;
      x4     <= skip_enable ? s_skip[15:0] : s_scaled[15:0];
      f4     <= f3 | s_scaled[16] | (skip_enable & s_skip[16]);
    end
  end

  cna_act #(.TABLE_SEGMENTS(TABLE_SEGMENTS)) u_act (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .x_in      (x4),
    .flag_in   (f4),
    .mode      (activation_mode),
    .out_valid (item_out.valid),
    .result    (item_out.result_value),
    .saturated (item_out.saturated)
  );

`ifndef SYNTHESIS
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready && item_in.cmd == CMD_RESTART)
    |=> (current_channel == 8'd0))
    else $error("channel not cleared after a restart item");

  a_load_keeps_channel: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready && item_in.cmd == CMD_LOAD)
    |=> $stable(current_channel))
    else $error("load item moved the channel counter");

  a_reset_empty: assert property (@(posedge clk) rst |=> !item_out.valid)
    else $error("result offered straight after reset");
`endif

endmodule

>>> dv/channel_norm_activation_core_tb.sv
// Testbench for channel_norm_activation_core: it streams load, process, restart and
// unused-code items through the pipeline and checks every result against a Q8.8 predictor.
// Needs cna_pkg, cna_in_if, cna_out_if, channel_norm_activation_core and its submodules.
module channel_norm_activation_core_tb;
  import cna_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SEGS = 256;
  localparam longint LN2_FIX = 64'sd186065280;
  localparam longint ONE_30 = 64'sd1 <<< 30;
  localparam longint LAMBDA_FIX = 64'sd68859;
  localparam longint ALPHA_FIX = 64'sd109659;
  localparam int PIPE_DEPTH = 11;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [1:0]         cmd;
    logic [7:0]         channel;
    logic signed [15:0] mean;
    logic signed [15:0] scale;
    logic signed [15:0] element;
    logic signed [15:0] skip;
  } elem_item_t;

  typedef struct {
    logic signed [15:0] value;
    logic               sat;
  } norm_result_t;

  logic clk;
  logic rst;
  logic write_enable;
  logic [REG_IDX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  cna_in_if in_ch();
  cna_out_if out_ch();

  channel_norm_activation_core dut (
    .clk(clk), .rst(rst), .item_in(in_ch), .item_out(out_ch),
    .write_enable(write_enable), .reg_index(reg_index), .write_data(write_data)
  );

  longint exp_knots[SEGS+1];
  longint tanh_knots[SEGS+1];
  longint sig_knots[SEGS+1];
  longint mish_knots[SEGS+1];
  logic signed [15:0] mean_mem[256];
  logic signed [15:0] scale_mem[256];
  int plane_pos;
  int chan;
  logic [8:0] cfg_channels;
  logic [12:0] cfg_spatial;
  logic cfg_layout;
  logic [2:0] cfg_act;
  logic cfg_skip;

  elem_item_t pending_items[$];
  norm_result_t expected_results[$];
  elem_item_t held;
  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint exp_fix32(longint y);
    longint a, n, r, term, sum;
    int k;
    a = y + LN2_FIX / 2;
    n = (a >= 0) ? a / LN2_FIX : -((-a + LN2_FIX - 1) / LN2_FIX);
    r = (y - n * LN2_FIX) * 16;
    term = 64'sd1 <<< 32;
    sum = term;
    for (k = 1; k <= 14; k++) begin
      term = (term * r) / (64'sd1 <<< 32) / longint'(k);
      sum = sum + term;
    end
    if (n >= 0) return sum <<< n;
    return (sum + (64'sd1 <<< (-n - 1))) >>> (-n);
  endfunction

  function automatic longint quotient16(longint num, longint den);
    return (num * 65536 + den / 2) / den;
  endfunction

  function automatic void build_knots();
    longint t, at, e1, e2, th, f2, nn;
    for (int k = 0; k <= SEGS; k++) begin
      t = -(64'sd1 <<< 31) + ((longint'(k) <<< 32) / SEGS);
      at = (t < 0) ? -t : t;
      e2 = exp_fix32(-2 * at) >>> 2;
      e1 = exp_fix32(-at) >>> 2;
      th = quotient16(ONE_30 - e2, ONE_30 + e2);
      exp_knots[k] = (exp_fix32(t) + 32768) >>> 16;
      tanh_knots[k] = (t < 0) ? -th : th;
      if (t >= 0) begin
        f2 = (e1 * e1) >>> 30;
        sig_knots[k] = quotient16(ONE_30, ONE_30 + e1);
        mish_knots[k] = quotient16(ONE_30 + 2 * e1, ONE_30 + 2 * e1 + 2 * f2);
      end else begin
        nn = ((e1 * e1) >>> 30) + 2 * e1;
        sig_knots[k] = quotient16(e1, ONE_30 + e1);
        mish_knots[k] = quotient16(nn, nn + 2 * ONE_30);
      end
    end
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip16(longint v, inout logic flag);
    if (v > 32767) begin
      flag = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      flag = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic longint interp(int which, longint x);
    longint u, p, i, f, lo, hi;
    u = x + 2048;
    if (u < 0) u = 0;
    if (u > 4096) u = 4096;
    p = u * SEGS;
    i = p >>> 12;
    f = p & 4095;
    case (which)
      TAB_EXP: begin
        lo = exp_knots[i];
        hi = (i < SEGS) ? exp_knots[i+1] : lo;
      end
      TAB_TANH: begin
        lo = tanh_knots[i];
        hi = (i < SEGS) ? tanh_knots[i+1] : lo;
      end
      TAB_SIG: begin
        lo = sig_knots[i];
        hi = (i < SEGS) ? sig_knots[i+1] : lo;
      end
      default: begin
        lo = mish_knots[i];
        hi = (i < SEGS) ? mish_knots[i+1] : lo;
      end
    endcase
    if (i >= SEGS) return lo;
    return lo + round_shift((hi - lo) * f, 12);
  endfunction

  function automatic longint activate(longint x, inout logic flag);
    longint v;
    case (cfg_act)
      ACT_RELU: return (x < 0) ? 0 : x;
      ACT_RELU_SQ: begin
        v = (x < 0) ? 0 : x;
        return clip16(round_shift(v * v, 8), flag);
      end
      ACT_TANH: return round_shift(interp(TAB_TANH, x), 8);
      ACT_SIGMOID: return round_shift(interp(TAB_SIG, x), 8);
      ACT_SELU: begin
        if (x >= 0) return clip16(round_shift(x * LAMBDA_FIX, 16), flag);
        v = round_shift((interp(TAB_EXP, x) - 65536) * ALPHA_FIX, 16);
        return clip16(round_shift(v * LAMBDA_FIX, 24), flag);
      end
      ACT_SWISH: return clip16(round_shift(x * interp(TAB_SIG, x), 16), flag);
      ACT_MISH: return clip16(round_shift(x * interp(TAB_MISH, x), 16), flag);
      default: return x;
    endcase
  endfunction

  function automatic void apply_item(elem_item_t it);
    longint x;
    logic flag;
    int cc, ss;
    norm_result_t res;
    flag = 1'b0;
    case (it.cmd)
      CMD_LOAD: begin
        mean_mem[it.channel] = it.mean;
        scale_mem[it.channel] = it.scale;
      end
      CMD_RESTART: begin
        plane_pos = 0;
        chan = 0;
      end
      CMD_PROCESS: begin
        x = clip16(longint'(it.element) - longint'(mean_mem[chan]), flag);
        x = clip16(round_shift(x * longint'(scale_mem[chan]), 8), flag);
        if (cfg_skip) x = clip16(x + longint'(it.skip), flag);
        x = activate(x, flag);
        res.value = x[15:0];
        res.sat = flag;
        expected_results.push_back(res);
        cc = (cfg_channels == 0) ? 1 : int'(cfg_channels);
        if (cc > 256) cc = 256;
        ss = (cfg_spatial == 0) ? 1 : int'(cfg_spatial);
        if (ss > 4096) ss = 4096;
        if (cfg_layout) begin
          chan = (chan + 1 >= cc) ? 0 : chan + 1;
        end else begin
          plane_pos = (plane_pos & 12'hfff) + 1;
          if (plane_pos >= ss) begin
            plane_pos = 0;
            chan = (chan + 1 >= cc) ? 0 : chan + 1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic elem_item_t random_item();
    elem_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.cmd = (pick < 84) ? CMD_PROCESS : (pick < 93) ? CMD_LOAD :
             (pick < 97) ? CMD_RESTART : CMD_UNUSED;
    it.channel = 8'($urandom);
    it.mean = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1024) - 512);
    it.scale = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1024) - 512);
    it.element = ($urandom_range(2) == 0) ? 16'($urandom) :
                 16'($urandom_range(2048) - 1024);
    it.skip = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(1024) - 512);
    return it;
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= data;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (PIPE_DEPTH + 5) @(negedge clk);
  endtask

  // Sender: holds an item until it is taken, then offers the next one or idles.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) apply_item(held);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= held.cmd;
          in_ch.load_channel <= held.channel;
          in_ch.load_mean <= held.mean;
          in_ch.load_scale <= held.scale;
          in_ch.element_value <= held.element;
          in_ch.skip_value <= held.skip;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and a field-by-field comparison of every result.
  always @(posedge clk) begin
    norm_result_t exp_res;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result value=%0d saturated=%0b",
                 out_ch.result_value, out_ch.saturated);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_ch.result_value !== exp_res.value) begin
            $error("result_value expected %0d actual %0d", exp_res.value,
                   out_ch.result_value);
            error_count++;
          end
          if (out_ch.saturated !== exp_res.sat) begin
            $error("saturated expected %0b actual %0b", exp_res.sat, out_ch.saturated);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[channel_norm_activation_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    elem_item_t it;
    int cc_sel, ss_sel;
    rst = 1'b1;
    write_enable = 1'b0;
    reg_index = '0;
    write_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOAD;
    in_ch.load_channel = '0;
    in_ch.load_mean = '0;
    in_ch.load_scale = '0;
    in_ch.element_value = '0;
    in_ch.skip_value = '0;
    out_ch.ready = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 18;
    recv_idle_pct = 83;
    plane_pos = 0;
    chan = 0;
    cfg_channels = 9'd1;
    cfg_spatial = 13'd64;
    cfg_layout = 1'b0;
    cfg_act = ACT_NONE;
    cfg_skip = 1'b0;
    build_knots();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Every channel entry is written before any element can read it.
    for (int c = 0; c < 256; c++) begin
      it = random_item();
      it.cmd = CMD_LOAD;
      it.channel = 8'(c);
      if (c == 0) begin
        it.mean = 16'sh8000;
        it.scale = 16'sh7fff;
      end else if (c == 1) begin
        it.mean = 16'sh7fff;
        it.scale = 16'sh8000;
      end else if (c < 4) begin
        it.mean = 16'sd0;
        it.scale = 16'sd256;
      end
      pending_items.push_back(it);
    end

    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 8) begin
        send_idle_pct = 83;
        recv_idle_pct = 18;
      end else if (ph == 16) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      cc_sel = $urandom_range(6);
      ss_sel = $urandom_range(6);
      if (ph < 7) begin
        cc_sel = ph;
        ss_sel = 6 - ph;
      end
      case (cc_sel)
        0: cfg_channels = 9'd0;
        1: cfg_channels = 9'd1;
        2: cfg_channels = 9'd256;
        3: cfg_channels = 9'd511;
        4: cfg_channels = 9'd300;
        default: cfg_channels = 9'($urandom_range(16, 2));
      endcase
      case (ss_sel)
        0: cfg_spatial = 13'd0;
        1: cfg_spatial = 13'd1;
        2: cfg_spatial = 13'd4096;
        3: cfg_spatial = 13'd8191;
        default: cfg_spatial = 13'($urandom_range(20, 2));
      endcase
      cfg_layout = (ph < 2) ? ph[0] : 1'($urandom_range(1));
      cfg_act = 3'(ph % 8);
      cfg_skip = (ph < 8) ? ph[1] : 1'($urandom_range(1));
      write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(cfg_channels));
      write_reg(REG_SPATIAL_SIZE, cfg_spatial);
      write_reg(REG_LAYOUT_MODE, CFG_DATA_W'(cfg_layout));
      write_reg(REG_ACTIVATION_MODE, CFG_DATA_W'(cfg_act));
      write_reg(REG_SKIP_ENABLE, CFG_DATA_W'(cfg_skip));
      @(posedge clk);
      write_enable <= 1'b0;

      if (ph < 8) begin
        for (int d = 0; d < 7; d++) begin
          it = random_item();
          it.cmd = CMD_PROCESS;
          case (d)
            0: it.element = 16'sh7fff;
            1: it.element = 16'sh8000;
            2: it.element = 16'sd0;
            3: it.element = 16'sh0800;
            4: it.element = -16'sh0800;
            5: it.cmd = CMD_UNUSED;
            default: it.cmd = CMD_RESTART;
          endcase
          it.skip = d[0] ? 16'sh7fff : 16'sh8000;
          pending_items.push_back(it);
        end
      end
      for (int n = 0; n < 27; n++) pending_items.push_back(random_item());
    end

    wait_drained();
    if (error_count == 0) begin
      $display("[channel_norm_activation_core] OK");
    end else begin
      $display("[channel_norm_activation_core] ERROR");
    end
    $finish;
  end

endmodule
